// ----- rtl/core/ews_pkg.sv -----
// Package for the energy word segmenter: payload types, register indexes and constants.
`timescale 1ns / 1ps

package ews_pkg;

  localparam int ENERGY_W = 16;
  localparam int HANG_W   = 4;
  localparam int LEN_W    = 11;
  localparam int SUM_W    = 27;
  localparam int PEND_W   = 20;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER_FRAMES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH       = 2'd2;

  localparam logic [ENERGY_W-1:0] THRESHOLD_RESET  = 16'd655;
  localparam logic [HANG_W-1:0]   HANGOVER_RESET   = 4'd3;
  localparam logic [LEN_W-1:0]    MIN_LENGTH_RESET = 11'd5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic [ENERGY_W-1:0] frame_energy;
    logic                stream_end;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] word_start;
    logic [LEN_W-1:0] word_end;
    logic [SUM_W-1:0] word_energy;
    logic             closed_by_end;
  } out_item_t;

endpackage

// ----- rtl/core/energy_word_segmenter.sv -----
// Energy word segmenter top level: threshold voice activity detection over frame energies.
`timescale 1ns / 1ps

// One frame energy transaction is accepted per clock cycle unless stalled.
// All segmentation work for a frame is done in a single registered pass, and
// a finished word is registered into the output or skid register. The output
// side holds up to two words (output register plus skid register); the input
// stalls only while both are occupied, so a frame that closes no word never
// waits on a stalled output beyond that. Frame indexes saturate at
// MAX_FRAME_COUNT - 1 and are reported in the low 11 bits.
module energy_word_segmenter
  import ews_pkg::*;
#(
  parameter int MAX_FRAME_COUNT = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int IW = $clog2(MAX_FRAME_COUNT);
  localparam int CW = (IW > LEN_W) ? IW : LEN_W;
  localparam int XW = IW + LEN_W;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_FRAME_COUNT - 1);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // configuration
  logic [ENERGY_W-1:0] thr_r;
  logic [HANG_W-1:0]   hang_r;
  logic [LEN_W-1:0]    min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      hang_r    <= HANGOVER_RESET;
      min_len_r <= MIN_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENERGY_THRESHOLD: thr_r     <= cfg_wdata[ENERGY_W-1:0];
        CFG_HANGOVER_FRAMES:  hang_r    <= cfg_wdata[HANG_W-1:0];
        CFG_MIN_LENGTH:       min_len_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // segmentation state
  logic              in_word_r, in_word_nxt;
  logic [IW-1:0]     frame_idx_r, frame_idx_nxt;
  logic [IW-1:0]     start_idx_r, start_idx_nxt;
  logic [HANG_W-1:0] quiet_cnt_r, quiet_cnt_nxt;
  logic [SUM_W-1:0]  active_sum_r, active_sum_nxt;
  logic [PEND_W-1:0] pending_sum_r, pending_sum_nxt;

  logic              accept;
  logic              loud;
  logic [HANG_W-1:0] hang_eff;
  logic [HANG_W-1:0] qc_inc;
  logic [IW:0]       end_lim;
  logic [IW-1:0]     end_idx;
  logic [IW-1:0]     hang_len;
  logic [IW-1:0]     flush_len;
  logic              res_valid;
  logic [IW-1:0]     res_start;
  logic [IW-1:0]     res_end;
  logic [SUM_W-1:0]  res_energy;
  logic              res_by_end;
  logic [XW-1:0]     res_start_x;
  logic [XW-1:0]     res_end_x;
  out_item_t         res_item;

  assign accept   = in_valid && !in_stall;
  assign loud     = in_data.frame_energy > thr_r;
  assign hang_eff = (hang_r == '0) ? HANG_W'(1) : hang_r;
  assign qc_inc   = quiet_cnt_r + HANG_W'(1);
  assign end_lim  = (IW+1)'(start_idx_r) + (IW+1)'(qc_inc);
  assign end_idx  = ({1'b0, frame_idx_r} >= end_lim) ? (frame_idx_r - IW'(qc_inc))
                                                     : start_idx_r;
  assign hang_len = end_idx - start_idx_r;

  always_comb begin
    in_word_nxt     = in_word_r;
    frame_idx_nxt   = frame_idx_r;
    start_idx_nxt   = start_idx_r;
    quiet_cnt_nxt   = quiet_cnt_r;
    active_sum_nxt  = active_sum_r;
    pending_sum_nxt = pending_sum_r;
    res_valid       = 1'b0;
    res_start       = start_idx_r;
    res_end         = end_idx;
    res_energy      = active_sum_r;
    res_by_end      = 1'b0;
    flush_len       = '0;

    if (loud) begin
      if (!in_word_r) begin
        in_word_nxt     = 1'b1;
        start_idx_nxt   = frame_idx_r;
        quiet_cnt_nxt   = '0;
        active_sum_nxt  = SUM_W'(in_data.frame_energy);
        pending_sum_nxt = '0;
      end else begin
        active_sum_nxt  = sat_add(sat_add(active_sum_r, SUM_W'(pending_sum_r)),
                                  SUM_W'(in_data.frame_energy));
        pending_sum_nxt = '0;
        quiet_cnt_nxt   = '0;
      end
    end else if (in_word_r) begin
      quiet_cnt_nxt   = qc_inc;
      pending_sum_nxt = pending_sum_r + PEND_W'(in_data.frame_energy);
      if (qc_inc >= hang_eff) begin
        if (CW'(hang_len) >= CW'(min_len_r)) begin
          res_valid = 1'b1;
        end
        in_word_nxt     = 1'b0;
        quiet_cnt_nxt   = '0;
        active_sum_nxt  = '0;
        pending_sum_nxt = '0;
      end
    end

    if (in_data.stream_end) begin
      flush_len = frame_idx_r - start_idx_nxt;
      if (in_word_nxt && (CW'(flush_len) >= CW'(min_len_r))) begin
        res_valid  = 1'b1;
        res_start  = start_idx_nxt;
        res_end    = frame_idx_r;
        res_energy = sat_add(active_sum_nxt, SUM_W'(pending_sum_nxt));
        res_by_end = 1'b1;
      end
      in_word_nxt     = 1'b0;
      frame_idx_nxt   = '0;
      start_idx_nxt   = '0;
      quiet_cnt_nxt   = '0;
      active_sum_nxt  = '0;
      pending_sum_nxt = '0;
    end else if (frame_idx_r < IDX_LAST) begin
      frame_idx_nxt = frame_idx_r + IW'(1);
    end
  end

  assign res_start_x            = XW'(res_start);
  assign res_end_x              = XW'(res_end);
  assign res_item.word_start    = res_start_x[LEN_W-1:0];
  assign res_item.word_end      = res_end_x[LEN_W-1:0];
  assign res_item.word_energy   = res_energy;
  assign res_item.closed_by_end = res_by_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_word_r     <= 1'b0;
      frame_idx_r   <= '0;
      start_idx_r   <= '0;
      quiet_cnt_r   <= '0;
      active_sum_r  <= '0;
      pending_sum_r <= '0;
    end else if (accept) begin
      in_word_r     <= in_word_nxt;
      frame_idx_r   <= frame_idx_nxt;
      start_idx_r   <= start_idx_nxt;
      quiet_cnt_r   <= quiet_cnt_nxt;
      active_sum_r  <= active_sum_nxt;
      pending_sum_r <= pending_sum_nxt;
    end
  end

  // output register plus skid register
  logic      out_valid_r;
  logic      skid_valid_r;
  out_item_t out_data_r;
  out_item_t skid_data_r;
  logic      out_take;
  logic      new_res;

  assign out_take  = out_valid_r && !out_stall;
  assign new_res   = accept && res_valid;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (new_res) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (new_res) begin
      if (out_valid_r && !out_take) begin
        skid_data_r <= res_item;
      end else begin
        out_data_r <= res_item;
      end
    end
  end

  // assertions
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_stall |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid word lost while output stalled");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word_r |-> (quiet_cnt_r == '0) && (pending_sum_r == '0) && (active_sum_r == '0))
    else $error("word accumulators not cleared outside a word");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.stream_end |=> !in_word_r && (frame_idx_r == '0))
    else $error("stream end did not clear segmentation state");

endmodule
